// File: rtl/core/chb_pkg.sv
// shared types and constants for the cumulative bucket histogram
package chb_pkg;

   localparam int unsigned BUCKET_LIMIT        = 6;
   localparam int unsigned MAX_BUCKETS_DEFAULT = 6;
   localparam int unsigned ACTION_W            = 2;
   localparam int unsigned SAMPLE_W            = 32;
   localparam int unsigned SEL_W               = 3;
   localparam int unsigned COUNT_W             = 40;
   localparam int unsigned SUM_W               = 64;
   localparam int unsigned USED_W              = 3;
   localparam int unsigned CSR_IDX_W           = 3;
   localparam int unsigned CSR_DATA_W          = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_OBSERVE = 2'd0,
      ACT_READ    = 2'd1,
      ACT_CLEAR   = 2'd2,
      ACT_SPARE   = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BOUND_ZERO   = 3'd0,
      REG_BOUND_ONE    = 3'd1,
      REG_BOUND_TWO    = 3'd2,
      REG_BOUND_THREE  = 3'd3,
      REG_BOUND_FOUR   = 3'd4,
      REG_BOUND_FIVE   = 3'd5,
      REG_BUCKETS_USED = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_REPORT,
      OP_OBSERVE,
      OP_CLEAR
   } op_type;

   // classified request handed from the front to the back
   typedef struct packed {
      op_type                    op;
      logic [SAMPLE_W-1:0]       sample;
      logic [BUCKET_LIMIT-1:0]   hit;
      logic [BUCKET_LIMIT-1:0]   pick;
      logic                      select_valid;
   } cmd_type;

endpackage

// File: rtl/core/chb_req_if.sv
// request channel interface
interface chb_req_if import chb_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic signed [SAMPLE_W-1:0] sample;
   logic [SEL_W-1:0]           bucket_select;

   modport source (output valid, action, sample, bucket_select, input ready);
   modport sink   (input valid, action, sample, bucket_select, output ready);
endinterface

// File: rtl/core/chb_rsp_if.sv
// response channel interface
interface chb_rsp_if import chb_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [COUNT_W-1:0]      bucket_count;
   logic                    select_valid;
   logic [COUNT_W-1:0]      total_count;
   logic signed [SUM_W-1:0] running_total;

   modport source (output valid, bucket_count, select_valid, total_count, running_total,
                   input ready);
   modport sink   (input valid, bucket_count, select_valid, total_count, running_total,
                   output ready);
endinterface

// File: rtl/core/chb_csr_if.sv
// configuration write channel interface
interface chb_csr_if import chb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/cumulative_bucket_histogram.sv
// top level of the cumulative bucket histogram
//
// usage: each request on req_bus is an observe (adds one to the total, the
// sample to the saturating Q48.16 sum, and one to every in-use bucket whose
// bound is at least the sample), a read, or a clear. every request yields one
// response on rsp_bus with the selected bucket's count and the totals after it.
// csr_bus writes bucket bounds (index 0..5) and the bucket count (index 6);
// it is always ready; the user must write it only while no request is in
// flight, which the block itself does not enforce. a request goes into the
// queue, then the back pops it into the response register; one request per
// cycle while responses are taken (compare combinational, update registered).
// a two-entry queue parts the two halves and the response is held in a
// register, so a stalled receiver first fills the queue; req_bus.ready drops
// once two requests wait behind the held response.
// reset clears bounds, bucket count, all counters, the sum and the queue.
module cumulative_bucket_histogram import chb_pkg::*; #(
   parameter int unsigned MAX_BUCKETS = MAX_BUCKETS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   chb_req_if.sink   req_bus,
   chb_rsp_if.source rsp_bus,
   chb_csr_if.sink   csr_bus
);

   logic    front_valid;
   logic    front_ready;
   cmd_type front_cmd;
   logic    back_valid;
   logic    back_ready;
   cmd_type back_cmd;

   chb_front #(
      .MAX_BUCKETS(MAX_BUCKETS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .csr_bus  (csr_bus),
      .cmd_valid(front_valid),
      .cmd_ready(front_ready),
      .cmd      (front_cmd)
   );

   chb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (front_valid),
      .in_ready (front_ready),
      .in_data  (front_cmd),
      .out_valid(back_valid),
      .out_ready(back_ready),
      .out_data (back_cmd)
   );

   chb_back #(
      .MAX_BUCKETS(MAX_BUCKETS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(back_valid),
      .cmd_ready(back_ready),
      .cmd      (back_cmd),
      .rsp_bus  (rsp_bus)
   );

endmodule

// File: rtl/core/chb_front.sv
// front end: configuration registers and request classification
module chb_front import chb_pkg::*; #(
   parameter int unsigned MAX_BUCKETS = MAX_BUCKETS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   chb_req_if.sink req_bus,
   chb_csr_if.sink csr_bus,
   output logic    cmd_valid,
   input  logic    cmd_ready,
   output cmd_type cmd
);

   logic signed [SAMPLE_W-1:0] bound_ff [MAX_BUCKETS];
   logic signed [SAMPLE_W-1:0] bound_in [MAX_BUCKETS];
   logic [USED_W-1:0]          used_ff;
   logic [USED_W-1:0]          used_in;
   logic [USED_W-1:0]          used_eff;
   logic                       csr_write;
   logic                       in_use;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_comb begin
      used_in = used_ff;
      for (int i = 0; i < MAX_BUCKETS; i++) begin
         bound_in[i] = bound_ff[i];
         if (csr_write && (csr_bus.index == CSR_IDX_W'(i))) begin
            bound_in[i] = csr_bus.data;
         end
      end
      if (csr_write && (csr_bus.index == REG_BUCKETS_USED)) begin
         used_in = csr_bus.data[USED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         for (int i = 0; i < MAX_BUCKETS; i++) begin
            bound_ff[i] <= '0;
         end
      end else begin
         used_ff <= used_in;
         for (int i = 0; i < MAX_BUCKETS; i++) begin
            bound_ff[i] <= bound_in[i];
         end
      end
   end

   // bucket count beyond the built buckets acts as all of them
   assign used_eff = (used_ff > USED_W'(MAX_BUCKETS)) ? USED_W'(MAX_BUCKETS) : used_ff;

   always_comb begin
      cmd.sample       = req_bus.sample;
      cmd.hit          = '0;
      cmd.pick         = '0;
      cmd.select_valid = (USED_W'(req_bus.bucket_select) < used_eff);
      in_use           = 1'b0;
      for (int i = 0; i < MAX_BUCKETS; i++) begin
         in_use      = (USED_W'(i) < used_eff);
         cmd.hit[i]  = in_use && (req_bus.sample <= bound_ff[i]);
         cmd.pick[i] = in_use && (req_bus.bucket_select == SEL_W'(i));
      end
      unique case (action_type'(req_bus.action))
         ACT_OBSERVE: cmd.op = OP_OBSERVE;
         ACT_CLEAR:   cmd.op = OP_CLEAR;
         ACT_READ,
         ACT_SPARE:   cmd.op = OP_REPORT;
         default:     cmd.op = OP_REPORT;
      endcase
   end

   assign cmd_valid     = req_bus.valid;
   assign req_bus.ready = cmd_ready;

endmodule

// File: rtl/core/chb_queue.sv
// two-entry queue between front and back
module chb_queue import chb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_data
);

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int unsigned FILL_W      = $clog2(QUEUE_DEPTH + 1);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              push;
   logic              pop;

   assign in_ready  = (fill_ff != FILL_W'(QUEUE_DEPTH));
   assign out_valid = (fill_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// File: rtl/core/chb_back.sv
// back end: counters, saturating sum and response register
module chb_back import chb_pkg::*; #(
   parameter int unsigned MAX_BUCKETS = MAX_BUCKETS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   chb_rsp_if.source   rsp_bus
);

   logic [COUNT_W-1:0]      counter_ff [MAX_BUCKETS];
   logic [COUNT_W-1:0]      counter_in [MAX_BUCKETS];
   logic [COUNT_W-1:0]      total_ff;
   logic [COUNT_W-1:0]      total_in;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] sum_in;
   logic [SUM_W:0]          sum_wide;
   logic [COUNT_W-1:0]      count_ff;
   logic [COUNT_W-1:0]      count_in;
   logic                    select_ff;
   logic                    rsp_valid_ff;
   logic                    pop;

   assign cmd_ready = !rsp_valid_ff || rsp_bus.ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      sum_wide = {sum_ff[SUM_W-1], sum_ff}
               + {{(SUM_W + 1 - SAMPLE_W){cmd.sample[SAMPLE_W-1]}}, cmd.sample};
      total_in = total_ff;
      sum_in   = sum_ff;
      for (int i = 0; i < MAX_BUCKETS; i++) begin
         counter_in[i] = counter_ff[i];
      end
      unique case (cmd.op)
         OP_OBSERVE: begin
            if (total_ff != COUNT_MAX) begin
               total_in = total_ff + COUNT_W'(1);
            end
            // overflow when the two top bits of the widened sum disagree
            if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
               sum_in = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                        : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
               sum_in = sum_wide[SUM_W-1:0];
            end
            for (int i = 0; i < MAX_BUCKETS; i++) begin
               if (cmd.hit[i] && (counter_ff[i] != COUNT_MAX)) begin
                  counter_in[i] = counter_ff[i] + COUNT_W'(1);
               end
            end
         end
         OP_CLEAR: begin
            total_in = '0;
            sum_in   = '0;
            for (int i = 0; i < MAX_BUCKETS; i++) begin
               counter_in[i] = '0;
            end
         end
         OP_REPORT: begin
         end
         default: begin
         end
      endcase
      count_in = '0;
      for (int i = 0; i < MAX_BUCKETS; i++) begin
         count_in = count_in | (cmd.pick[i] ? counter_in[i] : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_BUCKETS; i++) begin
            counter_ff[i] <= '0;
         end
      end else begin
         if (pop) begin
            total_ff <= total_in;
            sum_ff   <= sum_in;
            for (int i = 0; i < MAX_BUCKETS; i++) begin
               counter_ff[i] <= counter_in[i];
            end
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         count_ff  <= count_in;
         select_ff <= cmd.select_valid;
      end
   end

   // totals only move on a pop, which happens when no response is held or the held response leaves
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.bucket_count  = count_ff;
   assign rsp_bus.select_valid  = select_ff;
   assign rsp_bus.total_count   = total_ff;
   assign rsp_bus.running_total = sum_ff;

endmodule

// File: tb/chb_histogram_checker.sv
// response predictor and comparator for the cumulative bucket histogram
`timescale 1ns / 1ps
module chb_histogram_checker import chb_pkg::*; (
   input  logic clock,
   input  logic reset,
   chb_req_if   req_mon,
   chb_rsp_if   rsp_mon,
   chb_csr_if   csr_mon,
   output int   fail_count,
   output int   outstanding
);

   typedef struct packed {
      logic [COUNT_W-1:0]      bucket_count;
      logic                    select_valid;
      logic [COUNT_W-1:0]      total_count;
      logic signed [SUM_W-1:0] running_total;
   } report_type;

   logic signed [SAMPLE_W-1:0] bound_q [BUCKET_LIMIT];
   logic [USED_W-1:0]          used_q;
   logic [COUNT_W-1:0]         bucket_tally [BUCKET_LIMIT];
   logic [COUNT_W-1:0]         observe_tally;
   logic signed [SUM_W-1:0]    sample_sum;
   report_type                 pending_reports [$];

   // advances the histogram by one request and returns what the block should report
   function automatic report_type predict_histogram(logic [ACTION_W-1:0] act,
                                                    logic signed [SAMPLE_W-1:0] smp,
                                                    logic [SEL_W-1:0] sel);
      report_type              rep;
      int                      in_use;
      logic signed [SUM_W-1:0] wide_smp;
      logic signed [SUM_W-1:0] next_sum;
      in_use = (used_q > MAX_BUCKETS_DEFAULT) ? MAX_BUCKETS_DEFAULT : used_q;
      case (act)
         ACT_OBSERVE: begin
            if (observe_tally != COUNT_MAX) observe_tally = observe_tally + 1'b1;
            wide_smp = {{(SUM_W - SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
            next_sum = sample_sum + wide_smp;
            // same-sign operands with a flipped result sign: clamp
            if (!sample_sum[SUM_W-1] && !wide_smp[SUM_W-1] && next_sum[SUM_W-1])
               next_sum = {1'b0, {(SUM_W - 1){1'b1}}};
            else if (sample_sum[SUM_W-1] && wide_smp[SUM_W-1] && !next_sum[SUM_W-1])
               next_sum = {1'b1, {(SUM_W - 1){1'b0}}};
            sample_sum = next_sum;
            for (int i = 0; i < in_use; i++) begin
               if (smp <= bound_q[i] && bucket_tally[i] != COUNT_MAX)
                  bucket_tally[i] = bucket_tally[i] + 1'b1;
            end
         end
         ACT_CLEAR: begin
            for (int i = 0; i < BUCKET_LIMIT; i++) bucket_tally[i] = '0;
            observe_tally = '0;
            sample_sum    = '0;
         end
         default: ;
      endcase
      rep.select_valid  = (sel < in_use);
      rep.bucket_count  = rep.select_valid ? bucket_tally[sel] : '0;
      rep.total_count   = observe_tally;
      rep.running_total = sample_sum;
      return rep;
   endfunction

   always @(posedge clock) begin : monitor
      report_type want;
      bit         bad;
      if (reset) begin
         for (int i = 0; i < BUCKET_LIMIT; i++) begin
            bound_q[i]      = '0;
            bucket_tally[i] = '0;
         end
         used_q        = '0;
         observe_tally = '0;
         sample_sum    = '0;
         pending_reports.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index < REG_BUCKETS_USED)
               bound_q[csr_mon.index] = csr_mon.data;
            else if (csr_mon.index == REG_BUCKETS_USED)
               used_q = csr_mon.data[USED_W-1:0];
         end
         // responses trail their requests, so compare before queuing this edge's request
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_reports.size() == 0) begin
               $display("%0t: response with no request waiting, got count %0d total %0d",
                        $time, rsp_mon.bucket_count, rsp_mon.total_count);
               fail_count++;
            end else begin
               want = pending_reports.pop_front();
               bad  = 1'b0;
               if (rsp_mon.bucket_count !== want.bucket_count) begin
                  $display("%0t: bucket_count expected %0d, got %0d",
                           $time, want.bucket_count, rsp_mon.bucket_count);
                  bad = 1'b1;
               end
               if (rsp_mon.select_valid !== want.select_valid) begin
                  $display("%0t: select_valid expected %0d, got %0d",
                           $time, want.select_valid, rsp_mon.select_valid);
                  bad = 1'b1;
               end
               if (rsp_mon.total_count !== want.total_count) begin
                  $display("%0t: total_count expected %0d, got %0d",
                           $time, want.total_count, rsp_mon.total_count);
                  bad = 1'b1;
               end
               if (rsp_mon.running_total !== want.running_total) begin
                  $display("%0t: running_total expected %0d, got %0d",
                           $time, want.running_total, rsp_mon.running_total);
                  bad = 1'b1;
               end
               if (bad) fail_count++;
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_reports.insert(pending_reports.size(),
                                   predict_histogram(req_mon.action, req_mon.sample,
                                                     req_mon.bucket_select));
      end
      outstanding = pending_reports.size();
   end

endmodule

// File: tb/tb_cumulative_bucket_histogram.sv
// testbench top for the cumulative bucket histogram: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_cumulative_bucket_histogram;
   import chb_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int RANDOM_PHASES  = 7;
   localparam int PHASE_REQUESTS = 240;

   localparam logic [CSR_IDX_W-1:0]     REG_UNMAPPED = 3'd7;
   localparam logic signed [SAMPLE_W-1:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [SAMPLE_W-1:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [SAMPLE_W-1:0] Q_ONE = 32'sh0001_0000;

   logic clock;
   logic reset;
   int   fail_count;
   int   outstanding;
   int   cycle_count;
   bit   idle_enable = 1'b0;
   int   idle_odds   = 4;
   int   n_observe, n_read, n_clear, n_spare, n_setups;

   logic signed [SAMPLE_W-1:0] bounds_now [BUCKET_LIMIT];

   chb_req_if req_bus ();
   chb_rsp_if rsp_bus ();
   chb_csr_if csr_bus ();

   cumulative_bucket_histogram u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   chb_histogram_checker u_scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_mon     (csr_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // receiver side: random stall bursts while idling is on
   initial begin : rsp_side
      int burst;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (idle_enable && $urandom_range(0, idle_odds) == 0) begin
            burst = $urandom_range(1, 16);
            rsp_bus.ready <= 1'b0;
            repeat (burst) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // random Q16.16 value within about +/-8.0
   function automatic logic [SAMPLE_W-1:0] near_zero_q();
      logic [SAMPLE_W-1:0] r;
      r = $urandom;
      return {{12{r[19]}}, r[19:0]};
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll < 10)
         return bounds_now[$urandom_range(0, BUCKET_LIMIT - 1)] + $urandom_range(0, 4) - 2;
      else if (roll < 15)
         return near_zero_q();
      else if (roll == 15)
         return Q_MIN;
      else if (roll == 16)
         return Q_MAX;
      return $urandom;
   endfunction

   // called at a falling edge; valid stays high afterwards unless the next call idles
   task automatic issue_request(logic [ACTION_W-1:0] act, logic [SAMPLE_W-1:0] smp,
                                logic [SEL_W-1:0] sel);
      if (idle_enable && $urandom_range(0, idle_odds) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.action        <= act;
      req_bus.sample        <= smp;
      req_bus.bucket_select <= sel;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      case (act)
         ACT_OBSERVE: n_observe++;
         ACT_READ:    n_read++;
         ACT_CLEAR:   n_clear++;
         default:     n_spare++;
      endcase
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      if (idx < REG_BUCKETS_USED) bounds_now[idx] = val;
   endtask

   task automatic drain_histogram();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic apply_setup(input logic signed [SAMPLE_W-1:0] b [BUCKET_LIMIT],
                              input logic [USED_W-1:0] used);
      drain_histogram();
      write_register(REG_BOUND_ZERO, b[0]);
      write_register(REG_BOUND_ONE, b[1]);
      write_register(REG_BOUND_TWO, b[2]);
      write_register(REG_BOUND_THREE, b[3]);
      write_register(REG_BOUND_FOUR, b[4]);
      write_register(REG_BOUND_FIVE, b[5]);
      write_register(REG_UNMAPPED, $urandom);
      write_register(REG_BUCKETS_USED, {{(CSR_DATA_W - USED_W){1'b0}}, used});
      csr_bus.valid <= 1'b0;
      n_setups++;
   endtask

   initial begin : stimulus
      logic signed [SAMPLE_W-1:0] setup_bounds [BUCKET_LIMIT];
      logic [USED_W-1:0]          setup_used;
      int                         bq [$];
      int unsigned                roll;

      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.action        = ACT_READ;
      req_bus.sample        = '0;
      req_bus.bucket_select = '0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = REG_BOUND_ZERO;
      csr_bus.data          = '0;
      for (int i = 0; i < BUCKET_LIMIT; i++) bounds_now[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset setup has no buckets in use
      idle_enable = 1'b1;
      idle_odds   = 3;
      issue_request(ACT_OBSERVE, Q_ONE, 3'd0);
      issue_request(ACT_READ, Q_MIN, 3'd0);

      setup_bounds = '{Q_MIN, -Q_ONE, 32'sh0, Q_ONE, 32'sh0064_0000, Q_MAX};
      apply_setup(setup_bounds, 3'd6);
      issue_request(ACT_OBSERVE, Q_MIN, 3'd0);
      issue_request(ACT_OBSERVE, Q_MAX, 3'd5);
      issue_request(ACT_OBSERVE, 32'h0, 3'd2);
      issue_request(ACT_OBSERVE, 32'hffff_ffff, 3'd1);
      issue_request(ACT_OBSERVE, Q_ONE, 3'd3);
      issue_request(ACT_OBSERVE, Q_ONE + 1, 3'd4);
      for (int s = 0; s < 8; s++) issue_request(ACT_READ, $urandom, s[SEL_W-1:0]);
      issue_request(ACT_SPARE, Q_MAX, 3'd2);
      issue_request(ACT_CLEAR, Q_MIN, 3'd5);
      issue_request(ACT_READ, 32'h0, 3'd5);
      issue_request(ACT_OBSERVE, -Q_ONE, 3'd1);

      // shrink the bucket count, then raise it past the limit: upper counters keep value
      apply_setup(setup_bounds, 3'd3);
      issue_request(ACT_OBSERVE, Q_MIN, 3'd3);
      issue_request(ACT_READ, 32'h0, 3'd2);
      apply_setup(setup_bounds, 3'd7);
      issue_request(ACT_READ, 32'h0, 3'd3);
      issue_request(ACT_READ, 32'h0, 3'd5);
      issue_request(ACT_OBSERVE, Q_MAX, 3'd6);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         bq.delete();
         for (int i = 0; i < BUCKET_LIMIT; i++) begin
            case (phase)
               1:       bq.insert(bq.size(), int'(Q_MAX));
               2:       bq.insert(bq.size(), int'(Q_MIN));
               3, 4:    bq.insert(bq.size(), int'($urandom));
               default: bq.insert(bq.size(), int'(near_zero_q()));
            endcase
         end
         // one setup keeps its bounds out of order
         if (phase != 3) bq.sort();
         for (int i = 0; i < BUCKET_LIMIT; i++) setup_bounds[i] = bq[i];
         case (phase)
            1:       setup_used = 3'd7;
            3:       setup_used = USED_W'($urandom_range(0, 7));
            4:       setup_used = 3'd0;
            5:       setup_used = USED_W'($urandom_range(1, 5));
            default: setup_used = 3'd6;
         endcase
         apply_setup(setup_bounds, setup_used);
         idle_enable = (phase != RANDOM_PHASES - 1);
         idle_odds   = $urandom_range(2, 12);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
               issue_request(ACT_OBSERVE, pick_sample(), SEL_W'($urandom_range(0, 7)));
            else if (roll < 90)
               issue_request(ACT_READ, $urandom, SEL_W'($urandom_range(0, 7)));
            else if (roll < 95)
               issue_request(ACT_SPARE, $urandom, SEL_W'($urandom_range(0, 7)));
            else
               issue_request(ACT_CLEAR, $urandom, SEL_W'($urandom_range(0, 7)));
         end
      end

      drain_histogram();
      $display("covered %0d observes, %0d reads, %0d clears and %0d unused-code requests",
               n_observe, n_read, n_clear, n_spare);
      $display("over %0d bucket setups: extreme, unsorted and oversized bounds and counts",
               n_setups);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
